@@ rtl/core/bdg_pkg.sv @@
// Shared types, constants and the 3x7 font table for the big digit glyph renderer.
// No dependencies; used by bdg_col_gen and big_digit_glyph_renderer.
package bdg_pkg;

   localparam int CODE_W = 5;
   localparam int CNT_W  = 6;   // 64 bytes per glyph
   localparam int BYTE_W = 8;

   localparam logic [CNT_W-1:0] LAST_CNT = 6'd63;

   // Byte slots within one glyph
   localparam logic [CNT_W-1:0] SPACE_END = 6'd7;    // blank spacing
   localparam logic [CNT_W-1:0] LEFT_END  = 6'd23;   // left column, 4 repeats
   localparam logic [CNT_W-1:0] MID_END   = 6'd47;   // middle column, 6 repeats

   localparam logic [4:0] ROM_DEPTH = 5'd20;

   typedef logic [2:0][BYTE_W-1:0] font_row_type;  // [0] left, [1] mid, [2] right

   typedef enum logic [1:0] {
      COL_LEFT  = 2'd0,
      COL_MID   = 2'd1,
      COL_RIGHT = 2'd2,
      COL_NONE  = 2'd3
   } col_sel_type;

   function automatic font_row_type font_row(input logic [CODE_W-1:0] code);
      font_row_type r;
      case (code)
         5'd0:    r = {8'h7F, 8'h41, 8'h7F};
         5'd1:    r = {8'h7F, 8'h00, 8'h00};
         5'd2:    r = {8'h4F, 8'h49, 8'h79};
         5'd3:    r = {8'h7F, 8'h49, 8'h41};
         5'd4:    r = {8'h7E, 8'h08, 8'h0F};
         5'd5:    r = {8'h79, 8'h49, 8'h4F};
         5'd6:    r = {8'h79, 8'h49, 8'h7F};
         5'd7:    r = {8'h7F, 8'h01, 8'h03};
         5'd8:    r = {8'h7F, 8'h49, 8'h7F};
         5'd9:    r = {8'h7F, 8'h49, 8'h4F};
         5'd10:   r = {8'h7F, 8'h09, 8'h7F};
         5'd11:   r = {8'h78, 8'h48, 8'h7F};
         5'd12:   r = {8'h63, 8'h41, 8'h7F};
         5'd13:   r = {8'h7F, 8'h48, 8'h78};
         5'd14:   r = {8'h41, 8'h49, 8'h7F};
         5'd15:   r = {8'h01, 8'h09, 8'h7F};
         5'd16:   r = {8'h00, 8'h60, 8'h00};  // dot
         5'd17:   r = {8'h00, 8'h36, 8'h00};  // colon
         5'd18:   r = {8'h08, 8'h08, 8'h08};  // minus
         default: r = '0;                     // blank
      endcase
      return r;
   endfunction

endpackage

@@ rtl/core/bdg_col_gen.sv @@
// Column byte generator: maps glyph code and byte slot to one display byte.
// Depends on bdg_pkg.
module bdg_col_gen import bdg_pkg::*; #(
   parameter int GLYPH_COUNT = 20
) (
   input  logic [CODE_W-1:0] code,
   input  logic [CNT_W-1:0]  slot,
   output logic [BYTE_W-1:0] column_byte
);

   logic         blank;
   font_row_type row;
   col_sel_type  sel;
   logic [7:0]   fb;
   logic [1:0]   pair;

   always_comb begin
      blank = (code >= ROM_DEPTH) || ({1'b0, code} >= 6'(GLYPH_COUNT));
      row   = blank ? '0 : font_row(code);

      if (slot inside {[6'd0:SPACE_END]}) begin
         sel = COL_NONE;
      end else if (slot <= LEFT_END) begin
         sel = COL_LEFT;
      end else if (slot <= MID_END) begin
         sel = COL_MID;
      end else begin
         sel = COL_RIGHT;
      end

      case (sel)
         COL_LEFT:  fb = row[0];
         COL_MID:   fb = row[1];
         COL_RIGHT: fb = row[2];
         default:   fb = '0;
      endcase

      // Column sections start on multiples of 4, so the pair index is slot[1:0]
      pair        = fb[{slot[1:0], 1'b0} +: 2];
      column_byte = {{4{pair[1]}}, {4{pair[0]}}};
   end

endmodule

@@ rtl/core/big_digit_glyph_renderer.sv @@
// Big digit glyph renderer: one glyph code in, 64 column bytes out.
// The first byte passes through the generator stage, then the output register.
// One byte per cycle unless the output stalls; no new code is taken mid-glyph, but
// the next one is taken in the cycle the 64th byte moves into the output register.
// Reset (synchronous, active high) drops any glyph in progress and empties the output.
// Depends on bdg_pkg and bdg_col_gen.
module big_digit_glyph_renderer import bdg_pkg::*; #(
   parameter int GLYPH_COUNT = 20
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [CODE_W-1:0] req_glyph_code,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [BYTE_W-1:0] rsp_column_byte,
   output logic              rsp_last_byte
);

   // Generator stage: the held code and a byte slot counter
   logic              gen_valid_ff, gen_valid_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              advance;     // generator pushes a word into the output register
   logic              finishing;   // that word is the glyph's last
   logic              req_take;
   logic [BYTE_W-1:0] gen_byte;

   bdg_col_gen #(.GLYPH_COUNT(GLYPH_COUNT)) u_col_gen (
      .code        (code_ff),
      .slot        (cnt_ff),
      .column_byte (gen_byte)
   );

   always_comb begin
      // Output register frees up when empty or being taken this cycle
      advance   = gen_valid_ff && (!rsp_valid_ff || !rsp_stall);
      finishing = advance && (cnt_ff == LAST_CNT);
      // Accept a new code when idle, or in the same cycle the last word leaves
      req_stall = gen_valid_ff && !finishing;
      req_take  = req_valid && !req_stall;

      gen_valid_in = gen_valid_ff;
      code_in      = code_ff;
      cnt_in       = cnt_ff;
      if (req_take) begin
         gen_valid_in = 1'b1;
         code_in      = req_glyph_code;
         cnt_in       = '0;
      end else if (finishing) begin
         gen_valid_in = 1'b0;
      end else if (advance) begin
         cnt_in = cnt_ff + 6'd1;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = gen_byte;
         rsp_last_in  = (cnt_ff == LAST_CNT);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gen_valid_ff <= gen_valid_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload, no reset needed
   always_ff @(posedge clock) begin
      code_ff     <= code_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_column_byte = rsp_byte_ff;
   assign rsp_last_byte   = rsp_last_ff;

   // An idle generator never holds off the input
   a_idle_no_stall: assert property (@(posedge clock) disable iff (reset)
      !gen_valid_ff |-> !req_stall)
      else $error("input stalled while generator idle");

   // A taken code restarts the slot counter
   a_take_restarts: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (gen_valid_ff && cnt_ff == '0))
      else $error("slot counter not restarted on new code");

   // Spacing slots yield zero words
   a_spacing_zero: assert property (@(posedge clock) disable iff (reset)
      (advance && cnt_ff <= SPACE_END) |=> (rsp_valid && rsp_column_byte == '0))
      else $error("nonzero spacing word");

   // Font bit 7 is always clear, so the last word's high nibble is zero
   a_last_high_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_byte) |-> (rsp_column_byte[7:4] == 4'h0))
      else $error("last word has high nibble set");

   // The last word of a glyph frees the generator
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (finishing && !req_valid) |=> !gen_valid_ff)
      else $error("generator busy after last word");

endmodule

@@ dv/bdg_glyph_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for big_digit_glyph_renderer: renders every accepted glyph code into its
// 64 expected column words and checks the output words in order. Depends on bdg_pkg.
module bdg_glyph_checker import bdg_pkg::*; #(
   parameter int GLYPH_COUNT = 20
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [CODE_W-1:0] req_glyph_code,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [BYTE_W-1:0] rsp_column_byte,
   input  logic              rsp_last_byte,
   output int                mismatch_count,
   output int                words_pending
);

   localparam int SPACING_WORDS = 8;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [CNT_W-1:0]  slot;
      logic [BYTE_W-1:0] column_byte;
      logic              last_byte;
   } column_word_type;

   column_word_type column_q [$];

   initial begin
      mismatch_count = 0;
      words_pending  = 0;
   end

   // Font strokes {left, mid, right}; bit 0 is the top pixel.
   function automatic logic [23:0] glyph_strokes(input logic [CODE_W-1:0] code);
      logic [23:0] s;
      case (code)
         5'd0:    s = {8'h7F, 8'h41, 8'h7F};
         5'd1:    s = {8'h00, 8'h00, 8'h7F};
         5'd2:    s = {8'h79, 8'h49, 8'h4F};
         5'd3:    s = {8'h41, 8'h49, 8'h7F};
         5'd4:    s = {8'h0F, 8'h08, 8'h7E};
         5'd5:    s = {8'h4F, 8'h49, 8'h79};
         5'd6:    s = {8'h7F, 8'h49, 8'h79};
         5'd7:    s = {8'h03, 8'h01, 8'h7F};
         5'd8:    s = {8'h7F, 8'h49, 8'h7F};
         5'd9:    s = {8'h4F, 8'h49, 8'h7F};
         5'd10:   s = {8'h7F, 8'h09, 8'h7F};
         5'd11:   s = {8'h7F, 8'h48, 8'h78};
         5'd12:   s = {8'h7F, 8'h41, 8'h63};
         5'd13:   s = {8'h78, 8'h48, 8'h7F};
         5'd14:   s = {8'h7F, 8'h49, 8'h41};
         5'd15:   s = {8'h7F, 8'h09, 8'h01};
         5'd16:   s = {8'h00, 8'h60, 8'h00};
         5'd17:   s = {8'h00, 8'h36, 8'h00};
         5'd18:   s = {8'h08, 8'h08, 8'h08};
         default: s = '0;
      endcase
      return s;
   endfunction

   function automatic void push_word(input logic [CODE_W-1:0] code, input int slot,
                                     input logic [BYTE_W-1:0] value);
      column_word_type w;
      w.code        = code;
      w.slot        = slot[CNT_W-1:0];
      w.column_byte = value;
      w.last_byte   = (slot[CNT_W-1:0] == LAST_CNT);
      column_q.push_back(w);
   endfunction

   // Spacing, then each stroke column widened two font bits per word and repeated.
   function automatic void render_glyph(input logic [CODE_W-1:0] code);
      logic [23:0]       strokes;
      logic [BYTE_W-1:0] stroke;
      logic [BYTE_W-1:0] strip [4];
      col_sel_type       col;
      int                copies;
      int                slot;
      slot = 0;
      // codes past the font render blank
      if (code >= ROM_DEPTH || code >= GLYPH_COUNT)
         strokes = '0;
      else
         strokes = glyph_strokes(code);
      for (int n = 0; n < SPACING_WORDS; n++) begin
         push_word(code, slot, '0);
         slot++;
      end
      for (int c = 0; c < 3; c++) begin
         col    = col_sel_type'(c);
         stroke = strokes[(2 - c) * 8 +: 8];
         copies = (col == COL_MID) ? 6 : 4;
         for (int n = 0; n < 4; n++)
            strip[n] = {{4{stroke[2*n+1]}}, {4{stroke[2*n]}}};
         for (int r = 0; r < copies; r++) begin
            for (int n = 0; n < 4; n++) begin
               push_word(code, slot, strip[n]);
               slot++;
            end
         end
      end
   endfunction

   always @(posedge clock) begin : watch
      column_word_type want;
      if (reset) begin
         column_q.delete();
      end else begin
         if (req_valid && !req_stall)
            render_glyph(req_glyph_code);
         if (rsp_valid && !rsp_stall) begin
            if (column_q.size() == 0) begin
               if (mismatch_count < REPORT_LIMIT)
                  $display("%0t: column word %h last %b with nothing expected",
                           $realtime, rsp_column_byte, rsp_last_byte);
               mismatch_count++;
            end else begin
               want = column_q.pop_front();
               if (want.column_byte !== rsp_column_byte ||
                   want.last_byte !== rsp_last_byte) begin
                  if (mismatch_count < REPORT_LIMIT)
                     $display("%0t: code %0d word %0d: expected byte %h last %b, got byte %h last %b",
                              $realtime, want.code, want.slot, want.column_byte,
                              want.last_byte, rsp_column_byte, rsp_last_byte);
                  mismatch_count++;
               end
            end
         end
      end
      words_pending = column_q.size();
   end

endmodule

@@ dv/big_digit_glyph_renderer_tb.sv @@
`timescale 1ns / 1ps
// Top of the big_digit_glyph_renderer testbench: clock, reset, glyph code stimulus,
// output back-pressure and the verdict. Depends on bdg_pkg and bdg_glyph_checker.
module big_digit_glyph_renderer_tb;
   import bdg_pkg::*;

   localparam int GLYPHS       = 20;
   localparam int RANDOM_CODES = 420;
   localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
   localparam int SETTLE       = 20;    // extra cycles after the last word

   logic              clock          = 1'b0;
   logic              reset          = 1'b1;
   logic              req_valid      = 1'b0;
   logic              req_stall;
   logic [CODE_W-1:0] req_glyph_code = '0;
   logic              rsp_valid;
   logic              rsp_stall      = 1'b0;
   logic [BYTE_W-1:0] rsp_column_byte;
   logic              rsp_last_byte;

   // quiet: no idling on either side; hold_req: ask the receiver for its long hold-off
   logic              quiet          = 1'b0;
   logic              hold_req       = 1'b0;

   int                mismatch_count;
   int                words_pending;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   big_digit_glyph_renderer #(
      .GLYPH_COUNT (GLYPHS)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_glyph_code  (req_glyph_code),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_column_byte (rsp_column_byte),
      .rsp_last_byte   (rsp_last_byte)
   );

   bdg_glyph_checker #(
      .GLYPH_COUNT (GLYPHS)
   ) i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_glyph_code  (req_glyph_code),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_column_byte (rsp_column_byte),
      .rsp_last_byte   (rsp_last_byte),
      .mismatch_count  (mismatch_count),
      .words_pending   (words_pending)
   );

   // Receiver: random stalls (chance 6 in 100) unless quiet. On the first hold request
   // it stalls through its long hold-off, so the renderer fills and stalls its input.
   initial begin : receiver
      bit hold_served;
      hold_served = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req && !hold_served) begin
            hold_served = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_stall <= !quiet && ($urandom_range(0, 99) < 6);
         end
      end
   end

   // Offer one code, entered and left at a falling edge. Unless quiet, a random idle
   // gap may come first, so over the run gaps land on every phase of the 64-word glyph.
   task automatic send_code(input logic [CODE_W-1:0] code);
      int gap;
      if (!quiet && $urandom_range(0, 99) < 12) begin
         gap = $urandom_range(1, 70);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_glyph_code <= code;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   initial begin : stimulus
      logic [CODE_W-1:0] code;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: every font row, the first code past the font, the all-ones code,
      // and alternating bit patterns on the code field.
      for (int c = 0; c < GLYPHS; c++)
         send_code(c[CODE_W-1:0]);
      send_code(5'd20);
      send_code(5'd21);
      send_code(5'd10);
      send_code(5'd26);
      send_code(5'd31);

      // Random: mostly real glyphs, some codes beyond the font.
      for (int i = 0; i < RANDOM_CODES; i++) begin
         if (i == 60)
            hold_req <= 1'b1;
         if (i == 150) begin
            // drain completely before carrying on
            req_valid <= 1'b0;
            wait (words_pending == 0);
            @(negedge clock);
         end
         quiet <= (i >= 220 && i < 300);
         if ($urandom_range(0, 99) < 80)
            code = CODE_W'($urandom_range(0, GLYPHS - 1));
         else
            code = CODE_W'($urandom_range(GLYPHS, 31));
         send_code(code);
      end
      req_valid <= 1'b0;

      wait (words_pending == 0);
      repeat (SETTLE) @(posedge clock);
      if (mismatch_count == 0 && words_pending == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin : watchdog
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/bdg_pkg.sv
rtl/core/bdg_col_gen.sv
rtl/core/big_digit_glyph_renderer.sv
dv/bdg_glyph_checker.sv
dv/big_digit_glyph_renderer_tb.sv
